// ===== design/range_table_address_translate_top_assert.svh =====
// Assertion macros for the range table address translator checker.
// Included by the checker file only; expects clk and rst in scope.
`ifndef RANGE_TABLE_ADDRESS_TRANSLATE_TOP_ASSERT_SVH
`define RANGE_TABLE_ADDRESS_TRANSLATE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtat assertion failed");

// Next-cycle implication, checked outside reset.
`define RTAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtat assertion failed");

`endif

// ===== design/rtat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the range table address translator.
// No dependencies; used by rtat_cell, the top and the checker.
package rtat_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [63:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] file_offset;
  } out_item_t;

  // Query walking down the cell chain.
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [63:0] address;
    logic [63:0] byte_count;
    logic [63:0] pos;
  } token_t;

endpackage

// ===== design/rtat_cell.sv =====
`timescale 1ns / 1ps
// One table entry plus one stage of the query walk.
// Depends on rtat_pkg.
module rtat_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] count,
  input  logic             wr_en,
  input  logic [63:0]      wr_start,
  input  logic [63:0]      wr_size,
  input  rtat_pkg::token_t tok_in,
  output rtat_pkg::token_t tok_out
);
  import rtat_pkg::*;

  logic [63:0] start;
  logic [63:0] size;
  logic        active;
  logic        below;
  logic [63:0] off;
  logic        over;
  logic [63:0] rem;
  logic        fits;
  token_t      tok_next;

  assign active = (CNT_W'(IDX) < count);

  always_ff @(posedge clk) begin
    if (wr_en && count == CNT_W'(IDX)) begin
      start <= wr_start;
      size  <= wr_size;
    end
  end

  always_comb begin
    {below, off} = {1'b0, tok_in.address} - {1'b0, start};
    {over, rem}  = {1'b0, size} - {1'b0, off};
    fits         = !below && !over && (tok_in.byte_count <= rem);
    tok_next     = tok_in;
    if (tok_in.valid && !tok_in.hit && active) begin
      if (fits) begin
        tok_next.hit = 1'b1;
        tok_next.pos = tok_in.pos + off;
      end else begin
        tok_next.pos = tok_in.pos + size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.hit        <= tok_next.hit;
    tok_out.address    <= tok_next.address;
    tok_out.byte_count <= tok_next.byte_count;
    tok_out.pos        <= tok_next.pos;
  end

endmodule

// ===== design/range_table_address_translate_top.sv =====
`timescale 1ns / 1ps
// Range table address translator: clear, append and query on a table of ranges.
// Clear and append results go straight to the output register; a query first passes
// through every cell register of the chain and then the output register. One transaction
// at a time: a query holds off the input until it leaves the last cell, and the next
// transaction is taken once the output register is free or draining. Reset clears the
// range count, the base offset and all valid flags; entries are undefined until appended.
module range_table_address_translate_top #(
  parameter int MAX_RANGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtat_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rtat_pkg::out_item_t out_data
);
  import rtat_pkg::*;

  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  logic [63:0]      base_offset;
  logic [CNT_W-1:0] count;
  logic             in_flight;
  logic             in_acc;
  logic             full;
  logic             app_en;
  token_t           tok_head;
  token_t           tok [MAX_RANGES+1];

  assign in_stall = in_flight || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(MAX_RANGES));
  assign app_en   = in_acc && in_data.req_type == REQ_APPEND && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
    end else if (cfg_wr_en) begin
      base_offset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_acc && in_data.req_type == REQ_CLEAR) begin
      count <= '0;
    end else if (app_en) begin
      count <= count + CNT_W'(1);
    end
  end

  always_comb begin
    tok_head.valid      = in_acc && in_data.req_type == REQ_QUERY;
    tok_head.hit        = 1'b0;
    tok_head.address    = in_data.address;
    tok_head.byte_count = in_data.byte_count;
    tok_head.pos        = base_offset;
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    rtat_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .wr_en    (app_en),
      .wr_start (in_data.address),
      .wr_size  (in_data.byte_count),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Hold off new transactions until the query leaves the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
    end else if (tok_head.valid) begin
      in_flight <= 1'b1;
    end else if (tok[MAX_RANGES].valid) begin
      in_flight <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && in_data.req_type != REQ_QUERY) begin
      out_valid <= 1'b1;
    end else if (tok[MAX_RANGES].valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.req_type != REQ_QUERY) begin
      out_data.status      <= (in_data.req_type == REQ_APPEND && full) ? ST_FULL : ST_DONE;
      out_data.file_offset <= '0;
    end else if (tok[MAX_RANGES].valid) begin
      out_data.status      <= tok[MAX_RANGES].hit ? ST_FOUND : ST_MISS;
      out_data.file_offset <= tok[MAX_RANGES].hit ? tok[MAX_RANGES].pos : 64'd0;
    end
  end

endmodule

// ===== design/rtat_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the range table address translator, bound to the top.
// Depends on rtat_pkg and range_table_address_translate_top_assert.svh.
`include "range_table_address_translate_top_assert.svh"

module rtat_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input rtat_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rtat_pkg::out_item_t out_data
);
  import rtat_pkg::*;

  logic in_acc;
  logic off_zero;
  logic clear_ok;
  assign in_acc   = in_valid && !in_stall;
  assign off_zero = (out_data.file_offset == 64'd0);
  assign clear_ok = out_valid && out_data.status == ST_DONE && off_zero;

  `RTAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `RTAT_ASSERT_NEXT(a_clear_done, in_acc && in_data.req_type == REQ_CLEAR, clear_ok)
  `RTAT_ASSERT_NOW(a_miss_zero, out_valid && out_data.status != ST_FOUND, off_zero)
  `RTAT_ASSERT_NEXT(a_query_busy, in_acc && in_data.req_type == REQ_QUERY, in_stall && !out_valid)

endmodule

bind range_table_address_translate_top rtat_checker u_rtat_checker (.*);
